// ===== hdl/pts_pkg.sv =====
package pts_pkg;

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_CREATE  = 3'd1;
  localparam logic [2:0] ACT_START   = 3'd2;
  localparam logic [2:0] ACT_STOP    = 3'd3;
  localparam logic [2:0] ACT_DESTROY = 3'd4;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_IGNORED = 3'd1;
  localparam logic [2:0] ST_FIRED   = 3'd2;
  localparam logic [2:0] ST_IDLE    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  timer_slot;
    logic [30:0] interval_ticks;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] result_slot;
    logic       last;
  } res_t;

endpackage

// ===== hdl/pts_cmd_fifo.sv =====
module pts_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  pts_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output pts_pkg::cmd_t rd_data
);

  pts_pkg::cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule

// ===== hdl/pts_engine.sv =====
module pts_engine #(
  parameter int NUM_TIMERS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  pts_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output pts_pkg::res_t res
);

  localparam int NS = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
  localparam int SW = (NS > 1) ? $clog2(NS) : 1;
  localparam int CW = $clog2(NS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [31:0] time_r, time_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [NS-1:0] used_r, used_nxt, sched_r, sched_nxt;
  logic [NS-1:0] cand_r, cand_nxt;
  logic [30:0] period_r [NS];
  logic [31:0] due_r [NS];
  logic [31:0] order_r [NS];
  logic [CW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic [31:0]   bage_r, bage_nxt;
  logic          found_r, found_nxt;
  logic          ov_r, ov_nxt;
  pts_pkg::res_t ores_r, ores_nxt;

  logic          wr_en;
  logic [SW-1:0] wr_slot;
  logic [30:0]   wr_per;
  logic          per_we;
  logic          slot_ok;
  logic [SW-1:0] cslot;
  logic [SW-1:0] sidx;
  logic          cfree;
  logic [SW-1:0] free_slot;
  logic          out_free;
  logic          nxt_left;

  assign out_free  = !ov_r || res_ready;
  assign res_valid = ov_r;
  assign res       = ores_r;
  assign cmd_ready = (state_r == S_IDLE) && out_free;
  assign cslot     = cmd.timer_slot[SW-1:0];
  assign slot_ok   = ({28'd0, cmd.timer_slot} < 32'(NS)) && used_r[cslot];
  assign sidx      = idx_r[SW-1:0];

  always_comb begin
    cfree = 1'b0;
    free_slot = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        cfree = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    time_nxt  = time_r;
    seq_nxt   = seq_r;
    used_nxt  = used_r;
    sched_nxt = sched_r;
    cand_nxt  = cand_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    bage_nxt  = bage_r;
    found_nxt = found_r;
    ov_nxt    = ov_r && !res_ready;
    ores_nxt  = ores_r;
    wr_en     = 1'b0;
    wr_slot   = cslot;
    wr_per    = cmd.interval_ticks;
    per_we    = 1'b0;
    nxt_left  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          ov_nxt   = 1'b1;
          ores_nxt = '{status: pts_pkg::ST_IGNORED, result_slot: 4'd0, last: 1'b1};
          case (cmd.action)
            pts_pkg::ACT_TICK: begin
              ov_nxt    = 1'b0;
              time_nxt  = time_r + 32'd1;
              cand_nxt  = '0;
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
            pts_pkg::ACT_CREATE: begin
              if (cfree) begin
                used_nxt[free_slot]  = 1'b1;
                sched_nxt[free_slot] = 1'b0;
                ores_nxt.status      = pts_pkg::ST_DONE;
                ores_nxt.result_slot = 4'(free_slot);
              end else begin
                ores_nxt.status = pts_pkg::ST_FULL;
              end
            end
            pts_pkg::ACT_START: begin
              if (slot_ok && cmd.interval_ticks != 31'd0) begin
                wr_en  = 1'b1;
                per_we = 1'b1;
                sched_nxt[cslot] = 1'b1;
                seq_nxt = seq_r + 32'd1;
                ores_nxt.status = pts_pkg::ST_DONE;
              end
            end
            pts_pkg::ACT_STOP, pts_pkg::ACT_DESTROY: begin
              if (slot_ok) begin
                sched_nxt[cslot] = 1'b0;
                if (cmd.action == pts_pkg::ACT_DESTROY) used_nxt[cslot] = 1'b0;
                ores_nxt.status = pts_pkg::ST_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (used_r[sidx] && sched_r[sidx]
            && ((time_r - due_r[sidx]) & 32'h8000_0000) == 32'd0)
          cand_nxt[sidx] = 1'b1;
        if (idx_r == CW'(NS - 1)) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
        if (idx_r == CW'(NS - 1) && cand_nxt == '0) begin
          if (out_free) begin
            ov_nxt    = 1'b1;
            ores_nxt  = '{status: pts_pkg::ST_IDLE, result_slot: 4'd0, last: 1'b1};
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SCAN;
            idx_nxt   = idx_r;
          end
        end
      end
      default: begin
        // pass over candidates picking the oldest, then emit and rearm it
        if (idx_r != CW'(NS)) begin
          if (cand_r[sidx] && (!found_r || (seq_r - order_r[sidx]) > bage_r)) begin
            found_nxt = 1'b1;
            best_nxt  = sidx;
            bage_nxt  = seq_r - order_r[sidx];
          end
          idx_nxt = idx_r + CW'(1);
        end else if (out_free) begin
          cand_nxt[best_r] = 1'b0;
          nxt_left = cand_nxt != '0;
          ov_nxt   = 1'b1;
          ores_nxt = '{status: pts_pkg::ST_FIRED, result_slot: 4'(best_r),
                       last: !nxt_left};
          wr_en   = 1'b1;
          wr_slot = best_r;
          wr_per  = period_r[best_r];
          seq_nxt = seq_r + 32'd1;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if (!nxt_left) state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (per_we) period_r[wr_slot] <= cmd.interval_ticks;
    if (wr_en) begin
      due_r[wr_slot]   <= time_r + {1'b0, wr_per};
      order_r[wr_slot] <= seq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      time_r  <= '0;
      seq_r   <= '0;
      used_r  <= '0;
      sched_r <= '0;
      cand_r  <= '0;
      idx_r   <= '0;
      found_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      time_r  <= time_nxt;
      seq_r   <= seq_nxt;
      used_r  <= used_nxt;
      sched_r <= sched_nxt;
      cand_r  <= cand_nxt;
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    bage_r <= bage_nxt;
    ores_r <= ores_nxt;
  end

endmodule

// ===== hdl/periodic_timer_scheduler.sv =====
// a non-tick result is registered when the engine takes the command from the queue
// a tick scans the NS = min(NUM_TIMERS,16) usable slots in turn: an idle tick
// answers ST_IDLE; no command is taken until a tick's last fired slot is emitted
// throughput: one non-tick command per cycle while out_tready stays high
// a two-entry command queue lets new beats enter while a tick is in progress
// reset: synchronous active-low rst_n clears time, sequence and all slot flags
module periodic_timer_scheduler #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // action[2:0], timer_slot[6:3], interval_ticks[37:7]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // status[2:0], result_slot[6:3]
  output logic        out_tlast
);

  pts_pkg::cmd_t in_cmd, q_cmd;
  pts_pkg::res_t res;
  logic q_valid, q_ready;

  assign in_cmd = '{action: in_tdata[2:0], timer_slot: in_tdata[6:3],
                    interval_ticks: in_tdata[37:7]};

  pts_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_data(in_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  pts_engine #(.NUM_TIMERS(NUM_TIMERS)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {1'b0, res.result_slot, res.status};
  assign out_tlast = res.last;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_fired_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != pts_pkg::ST_FIRED && out_tdata[2:0] != pts_pkg::ST_DONE
    |-> out_tdata[6:3] == 4'd0 && out_tlast)
    else $error("bad non-fire result");
`endif

endmodule

// ===== verif/periodic_timer_scheduler_test.sv =====
module periodic_timer_scheduler_test;

  localparam int NT = 16;
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  periodic_timer_scheduler #(.NUM_TIMERS(NT)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #10 clk = ~clk;

  // timer table mirror
  logic [31:0] tnow, seq_cnt;
  logic        used[NT], armed[NT];
  logic [30:0] period[NT];
  logic [31:0] due[NT], order[NT];

  pts_pkg::res_t pending_res[$];
  int   errors = 0;
  int   cycles = 0;
  int   send_idle = 0, recv_stall = 0;
  bit   hold_off = 1'b0;

  function automatic pts_pkg::res_t mk(logic [2:0] st, logic [3:0] sl, logic la);
    pts_pkg::res_t r;
    r.status = st; r.result_slot = sl; r.last = la;
    return r;
  endfunction

  task automatic arm_slot(int s, logic [30:0] p);
    period[s] = p;
    due[s] = tnow + {1'b0, p};
    order[s] = seq_cnt;
    seq_cnt = seq_cnt + 32'd1;
    armed[s] = 1'b1;
  endtask

  task automatic predict_cmd(pts_pkg::cmd_t c);
    int list[$];
    int i, j, v, s;
    bit ok;
    s = int'(c.timer_slot);
    ok = used[s];
    case (c.action)
      pts_pkg::ACT_TICK: begin
        tnow = tnow + 32'd1;
        for (i = 0; i < NT; i++)
          if (used[i] && armed[i] && !((tnow - due[i]) & 32'h8000_0000)) list.push_back(i);
        for (i = 1; i < list.size(); i++) begin
          v = list[i];
          j = i - 1;
          while (j >= 0 && (seq_cnt - order[list[j]]) < (seq_cnt - order[v])) begin
            list[j+1] = list[j];
            j--;
          end
          list[j+1] = v;
        end
        if (list.size() == 0) pending_res.push_back(mk(pts_pkg::ST_IDLE, 4'd0, 1'b1));
        for (i = 0; i < list.size(); i++) begin
          pending_res.push_back(mk(pts_pkg::ST_FIRED, 4'(list[i]), i == list.size() - 1));
          arm_slot(list[i], period[list[i]]);
        end
      end
      pts_pkg::ACT_CREATE: begin
        v = -1;
        for (i = 0; i < NT; i++) if (v < 0 && !used[i]) v = i;
        if (v < 0) pending_res.push_back(mk(pts_pkg::ST_FULL, 4'd0, 1'b1));
        else begin
          used[v] = 1'b1; armed[v] = 1'b0;
          pending_res.push_back(mk(pts_pkg::ST_DONE, 4'(v), 1'b1));
        end
      end
      pts_pkg::ACT_START: begin
        if (ok && c.interval_ticks != 31'd0) begin
          arm_slot(s, c.interval_ticks);
          pending_res.push_back(mk(pts_pkg::ST_DONE, 4'd0, 1'b1));
        end else pending_res.push_back(mk(pts_pkg::ST_IGNORED, 4'd0, 1'b1));
      end
      pts_pkg::ACT_STOP, pts_pkg::ACT_DESTROY: begin
        if (ok) begin
          armed[s] = 1'b0;
          if (c.action == pts_pkg::ACT_DESTROY) used[s] = 1'b0;
          pending_res.push_back(mk(pts_pkg::ST_DONE, 4'd0, 1'b1));
        end else pending_res.push_back(mk(pts_pkg::ST_IGNORED, 4'd0, 1'b1));
      end
      default: pending_res.push_back(mk(pts_pkg::ST_IGNORED, 4'd0, 1'b1));
    endcase
  endtask

  function automatic pts_pkg::cmd_t mkc(logic [2:0] a, logic [3:0] s, logic [30:0] iv);
    pts_pkg::cmd_t c;
    c.action = a; c.timer_slot = s; c.interval_ticks = iv;
    return c;
  endfunction

  // called at a falling edge; leaves tvalid high for a back to back beat
  task automatic send(pts_pkg::cmd_t c);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {2'b00, c.interval_ticks, c.timer_slot, c.action};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_cmd(c);
    @(negedge clk);
  endtask

  task automatic send_expect(pts_pkg::cmd_t c, pts_pkg::res_t r);
    send(c);
    if (pending_res[pending_res.size()-1] != r) begin
      $display("%0t directed row: expected %p got %p", $time, r,
               pending_res[pending_res.size()-1]);
      errors++;
    end
  endtask

  task automatic drain;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // output checker
  always @(posedge clk) begin
    pts_pkg::res_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = mk(out_tdata[2:0], out_tdata[6:3], out_tlast);
      if (pending_res.size() == 0) begin
        $display("%0t unexpected beat: expected none got %p", $time, got);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (got != want) begin
          $display("%0t mismatch: expected %p got %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(negedge clk)
    out_tready <= !hold_off && !(recv_stall > 0 && $urandom_range(99) < recv_stall);

  always @(posedge clk)
    if (cycles > CYCLE_LIMIT) begin
      $display("periodic_timer_scheduler verification failed");
      $finish;
    end

  task automatic rand_phase(int n);
    int k, s;
    logic [30:0] iv;
    for (k = 0; k < n; k++) begin
      s = $urandom_range(99);
      if (s < 45) send(mkc(pts_pkg::ACT_TICK, 4'($urandom), 31'd0));
      else if (s < 58) send(mkc(pts_pkg::ACT_CREATE, 4'($urandom), 31'($urandom)));
      else if (s < 78) begin
        iv = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(6));
        send(mkc(pts_pkg::ACT_START, 4'($urandom_range(5)), iv));
      end else if (s < 86)
        send(mkc(pts_pkg::ACT_STOP, 4'($urandom_range(7)), 31'($urandom)));
      else if (s < 94)
        send(mkc(pts_pkg::ACT_DESTROY, 4'($urandom_range(7)), 31'($urandom)));
      else send(mkc(3'($urandom_range(7)), 4'($urandom), 31'($urandom)));
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    int i;
    pts_pkg::cmd_t rows[$];
    pts_pkg::res_t rexp[$];
    bit   rchk[$];
    tnow = 0; seq_cnt = 0;
    for (i = 0; i < NT; i++) begin
      used[i] = 0; armed[i] = 0; period[i] = 0; due[i] = 0; order[i] = 0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    rows = {mkc(pts_pkg::ACT_TICK, 4'd0, 31'd0), mkc(pts_pkg::ACT_START, 4'd0, 31'd5),
            mkc(pts_pkg::ACT_STOP, 4'd15, 31'd0), mkc(pts_pkg::ACT_DESTROY, 4'd3, 31'd0),
            mkc(3'd5, 4'd0, 31'd0), mkc(3'd7, 4'd15, 31'h7fffffff),
            mkc(pts_pkg::ACT_CREATE, 4'd0, 31'd0), mkc(pts_pkg::ACT_CREATE, 4'd0, 31'd0),
            mkc(pts_pkg::ACT_START, 4'd0, 31'd0), mkc(pts_pkg::ACT_START, 4'd0, 31'd1),
            mkc(pts_pkg::ACT_START, 4'd1, 31'd1), mkc(pts_pkg::ACT_TICK, 4'd0, 31'd0),
            mkc(pts_pkg::ACT_TICK, 4'd0, 31'd0),
            mkc(pts_pkg::ACT_START, 4'd1, 31'h7fffffff),
            mkc(pts_pkg::ACT_TICK, 4'd0, 31'd0), mkc(pts_pkg::ACT_STOP, 4'd0, 31'd0),
            mkc(pts_pkg::ACT_TICK, 4'd0, 31'd0), mkc(pts_pkg::ACT_DESTROY, 4'd0, 31'd0),
            mkc(pts_pkg::ACT_DESTROY, 4'd0, 31'd0), mkc(pts_pkg::ACT_CREATE, 4'd0, 31'd0)};
    rexp = {mk(pts_pkg::ST_IDLE, 4'd0, 1'b1), mk(pts_pkg::ST_IGNORED, 4'd0, 1'b1),
            mk(pts_pkg::ST_IGNORED, 4'd0, 1'b1), mk(pts_pkg::ST_IGNORED, 4'd0, 1'b1),
            mk(pts_pkg::ST_IGNORED, 4'd0, 1'b1), mk(pts_pkg::ST_IGNORED, 4'd0, 1'b1),
            mk(pts_pkg::ST_DONE, 4'd0, 1'b1), mk(pts_pkg::ST_DONE, 4'd1, 1'b1),
            mk(pts_pkg::ST_IGNORED, 4'd0, 1'b1), mk(pts_pkg::ST_DONE, 4'd0, 1'b1),
            mk(pts_pkg::ST_DONE, 4'd0, 1'b1), mk(3'd0, 4'd0, 1'b0), mk(3'd0, 4'd0, 1'b0),
            mk(pts_pkg::ST_DONE, 4'd0, 1'b1), mk(3'd0, 4'd0, 1'b0),
            mk(pts_pkg::ST_DONE, 4'd0, 1'b1), mk(pts_pkg::ST_IDLE, 4'd0, 1'b1),
            mk(pts_pkg::ST_DONE, 4'd0, 1'b1), mk(pts_pkg::ST_IGNORED, 4'd0, 1'b1),
            mk(pts_pkg::ST_DONE, 4'd0, 1'b1)};
    rchk = {1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
            1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    for (i = 0; i < rows.size(); i++)
      if (rchk[i]) send_expect(rows[i], rexp[i]);
      else send(rows[i]);
    // fill the table, then full
    for (i = 0; i < NT; i++) send(mkc(pts_pkg::ACT_CREATE, 4'd0, 31'd0));
    for (i = 0; i < NT; i++) send(mkc(pts_pkg::ACT_START, 4'(i), 31'd1));
    send(mkc(pts_pkg::ACT_TICK, 4'd0, 31'd0));
    in_tvalid <= 1'b0;
    drain();

    send_idle = 0;  recv_stall = 0;  rand_phase(30); drain();
    send_idle = 88; recv_stall = 0;  rand_phase(20); drain();
    send_idle = 0;  recv_stall = 88; rand_phase(20); drain();
    send_idle = 34; recv_stall = 34; rand_phase(30); drain();

    // long receiver hold-off while commands keep coming
    send_idle = 0; recv_stall = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      rand_phase(20);
    join
    drain();

    if (errors == 0)
      $display("periodic_timer_scheduler verification clean");
    else
      $display("periodic_timer_scheduler verification failed");
    $finish;
  end
endmodule
